// ===== hw/rtl/hid_key_report_tracker_unit_macros.svh =====
// Assertion macros shared by the key report tracker RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef HID_KEY_REPORT_TRACKER_UNIT_MACROS_SVH
`define HID_KEY_REPORT_TRACKER_UNIT_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge, disabled while reset is low.
`define HKRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("hkrt assertion failed");
// Checked on every rising edge, reset included.
`define HKRT_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("hkrt assertion failed");
`else
`define HKRT_ASSERT(label, clk, rst_n, prop)
`define HKRT_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

// ===== hw/rtl/hkrt_pkg.sv =====
// Package for the key report tracker: constants, mode codes and item types.
// No dependencies; imported by every module of the block.
package hkrt_pkg;

    localparam int KEY_SLOTS  = 6;
    localparam int MODE_W     = 3;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 56;

    localparam logic [7:0] MOD_FIRST = 8'hE0;
    localparam logic [7:0] MOD_END   = 8'hE8;
    localparam logic [7:0] KEY_END   = 8'hA5;
    localparam logic [7:0] EMPTY     = 8'h00;

    typedef enum logic [MODE_W-1:0] {
        MODE_PRESS   = 3'd0,
        MODE_RELEASE = 3'd1,
        MODE_TOGGLE  = 3'd2,
        MODE_REL_ALL = 3'd3,
        MODE_LOAD    = 3'd4,
        MODE_QUIET   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0]                 mods;
        logic [KEY_SLOTS-1:0][7:0]  keys;
    } t_report;

    typedef struct packed {
        t_mode                      mode;
        logic [7:0]                 code;
        logic [7:0]                 load_mods;
        logic [KEY_SLOTS-1:0][7:0]  load_keys;
    } t_event;

    typedef struct packed {
        logic    valid;
        t_report report;
    } t_result;

endpackage

// ===== hw/rtl/hid_key_report_tracker_unit.sv =====
// Top level of the boot-keyboard report tracker.
// Depends on hkrt_pkg, hkrt_event_reg, hkrt_report_core and hkrt_out_reg.
//
// Usage:
//   Slave channel: one key event per item. tuser carries the mode (press,
//   release, toggle modifier, release all, load report, quiet clear);
//   tdata carries the key code, the load modifier byte and six load slots.
//   Master channel: one report item (modifier byte, six key slots) each
//   time an event other than a quiet clear changes the report relative
//   to the last one sent. Events that change nothing visible produce no item.
//   Path: an accepted event passes the input register, then a combinational
//   update into the output register, from which the report item can be
//   taken.
//   Throughput: one event per cycle while the receiver keeps up; the
//   update stage advances only when the output register is free or being
//   emptied, so that loop sets the rate.
//   Reset (i_rst_n low, synchronous) empties both registers and clears the
//   held and last-sent reports to all zero.
//   When the receiver stalls, the pending report holds and the input
//   register still takes one more event; then tready drops.
module hid_key_report_tracker_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // [7:0] key_code, [15:8] load_modifiers, [23:16] load_key0 ... [63:56] load_key5
    input  logic [hkrt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [2:0] mode
    input  logic [hkrt_pkg::MODE_W-1:0]     i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // [7:0] out_modifiers, [15:8] out_key0 ... [55:48] out_key5
    output logic [hkrt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata
);
    import hkrt_pkg::*;

    t_event  in_event;
    t_event  stage_event;
    logic    stage_valid;
    logic    out_free;
    logic    go;
    t_result result;
    t_report out_report;

    // unpack the input item
    always_comb begin
        in_event.mode      = t_mode'(i_s_axis_tuser);
        in_event.code      = i_s_axis_tdata[7:0];
        in_event.load_mods = i_s_axis_tdata[15:8];
        in_event.load_keys = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            in_event.load_keys[i] = i_s_axis_tdata[16 + 8*i +: 8];
        end
    end

    assign go = stage_valid && out_free;

    hkrt_event_reg u_event_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .i_event (in_event),
        .i_take  (go),
        .o_ready (o_s_axis_tready),
        .o_valid (stage_valid),
        .o_event (stage_event)
    );

    hkrt_report_core u_report_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_event  (stage_event),
        .o_result (result)
    );

    hkrt_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_result (result),
        .i_ready  (i_m_axis_tready),
        .o_free   (out_free),
        .o_valid  (o_m_axis_tvalid),
        .o_report (out_report)
    );

    // pack the report item; slots past KEY_SLOTS read as zero
    always_comb begin
        o_m_axis_tdata       = '0;
        o_m_axis_tdata[7:0]  = out_report.mods;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            o_m_axis_tdata[8 + 8*i +: 8] = out_report.keys[i];
        end
    end

endmodule

// ===== hw/rtl/hkrt_event_reg.sv =====
// Input register of the key report tracker: captures one event item.
// Depends on hkrt_pkg.
module hkrt_event_reg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  hkrt_pkg::t_event              i_event,
    input  logic                          i_take,
    output logic                          o_ready,
    output logic                          o_valid,
    output hkrt_pkg::t_event              o_event
);
    import hkrt_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_event r_event;
    logic   load;

    // free slot, or the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign load    = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_event <= i_event;
        end
    end

    assign o_valid = r_valid;
    assign o_event = r_event;

endmodule

// ===== hw/rtl/hkrt_report_core.sv =====
// Report state and update logic: held and last-sent reports, send decision.
// Depends on hkrt_pkg and the assertion macro header.
`include "hid_key_report_tracker_unit_macros.svh"

module hkrt_report_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  hkrt_pkg::t_event     i_event,
    output hkrt_pkg::t_result    o_result
);
    import hkrt_pkg::*;

    t_report r_held;
    t_report r_sent;
    t_report n_held;
    logic    try_send;
    logic    emit;

    logic       is_mod;
    logic       is_key;
    logic [7:0] mod_bit;
    logic       present;
    logic       found;
    logic [KEY_SLOTS-1:0] place;

    // code classification
    always_comb begin
        is_mod  = (i_event.code >= MOD_FIRST) && (i_event.code < MOD_END);
        is_key  = (i_event.code != EMPTY) && (i_event.code < KEY_END);
        mod_bit = 8'd1 << i_event.code[2:0];
    end

    // six-way slot compare and first empty slot pick
    always_comb begin
        present = 1'b0;
        found   = 1'b0;
        place   = '0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            if (r_held.keys[i] == i_event.code) begin
                present = 1'b1;
            end
            if (!found && (r_held.keys[i] == EMPTY)) begin
                found    = 1'b1;
                place[i] = 1'b1;
            end
        end
    end

    // next held report and whether a send is attempted
    always_comb begin
        n_held   = r_held;
        try_send = 1'b0;
        case (i_event.mode)
            MODE_PRESS: begin
                if (is_mod) begin
                    n_held.mods = r_held.mods | mod_bit;
                    try_send    = 1'b1;
                end else if (is_key) begin
                    if (present) begin
                        try_send = 1'b1;
                    end else if (found) begin
                        for (int i = 0; i < KEY_SLOTS; i++) begin
                            if (place[i]) begin
                                n_held.keys[i] = i_event.code;
                            end
                        end
                        try_send = 1'b1;
                    end
                end
            end
            MODE_RELEASE: begin
                if (is_mod) begin
                    n_held.mods = r_held.mods & ~mod_bit;
                    try_send    = 1'b1;
                end else if (is_key) begin
                    for (int i = 0; i < KEY_SLOTS; i++) begin
                        if (r_held.keys[i] == i_event.code) begin
                            n_held.keys[i] = EMPTY;
                        end
                    end
                    try_send = 1'b1;
                end
            end
            MODE_TOGGLE: begin
                if (is_mod) begin
                    n_held.mods = r_held.mods ^ mod_bit;
                end
                try_send = 1'b1;
            end
            MODE_REL_ALL: begin
                n_held   = '0;
                try_send = 1'b1;
            end
            MODE_LOAD: begin
                n_held.mods = i_event.load_mods;
                n_held.keys = i_event.load_keys;
                try_send    = 1'b1;
            end
            MODE_QUIET: begin
                n_held = '0;
            end
            default: begin
                n_held = r_held;
            end
        endcase
    end

    // send only when the report changed since the last one emitted
    assign emit = try_send && (n_held != r_sent);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_sent <= '0;
        end else if (i_go) begin
            r_held <= n_held;
            if (emit) begin
                r_sent <= n_held;
            end
        end
    end

    assign o_result.valid  = i_go && emit;
    assign o_result.report = n_held;

    `HKRT_ASSERT(a_emit_syncs_sent, i_clk, i_rst_n, o_result.valid |=> (r_sent == r_held))
    `HKRT_ASSERT(a_idle_holds_state, i_clk, i_rst_n, !i_go |=> ($stable(r_held) && $stable(r_sent)))
    `HKRT_ASSERT(a_sent_only_on_emit, i_clk, i_rst_n, (i_go && !emit) |=> $stable(r_sent))
    `HKRT_ASSERT_ALWAYS(a_result_needs_go, i_clk, o_result.valid |-> i_go)

endmodule

// ===== hw/rtl/hkrt_out_reg.sv =====
// Output register of the key report tracker: holds one report item for the receiver.
// Depends on hkrt_pkg.
module hkrt_out_reg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hkrt_pkg::t_result    i_result,
    input  logic                 i_ready,
    output logic                 o_free,
    output logic                 o_valid,
    output hkrt_pkg::t_report    o_report
);
    import hkrt_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_report r_report;

    // register empty, or its item is taken this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (o_free) begin
            n_valid = i_result.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_result.valid) begin
            r_report <= i_result.report;
        end
    end

    assign o_valid  = r_valid;
    assign o_report = r_report;

endmodule
